>>> hw/rtl/afc_pkg.sv
// Shared constants and types for the AABB frustum cull block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package afc_pkg;

  localparam int REG_COUNT  = 6;   // plane registers on the APB port
  localparam int PLANE_W    = 64;  // a, b, c, d packed 16 bits each
  localparam int COEF_W     = 16;  // width of one plane coefficient
  localparam int D_ALIGN    = 14;  // Q12.4 offset aligned to Q.18
  localparam int D_W        = COEF_W + D_ALIGN;
  localparam int CFG_ADDR_W = 6;   // byte addresses 8*i for six registers
  localparam int CFG_DATA_W = 64;
  localparam int OUT_W      = 8;   // visible flag padded to a byte

  // coefficient positions inside a plane register
  localparam int POS_A = 3;
  localparam int POS_B = 2;
  localparam int POS_C = 1;
  localparam int POS_D = 0;

  typedef logic [PLANE_W-1:0] plane_t;

  // load strobe and input valid for the product stage of each plane unit
  typedef struct packed {
    logic load;
    logic valid;
  } stage_ctl_t;

endpackage

>>> hw/rtl/afc_plane_regs.sv
// APB register file holding the frustum planes.
// Depends on afc_pkg for register count, address and data widths.
`timescale 1ns / 1ps

module afc_plane_regs #(
  parameter int NUM_PLANES = 6
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [afc_pkg::CFG_ADDR_W-1:0]           paddr,
  input  logic [afc_pkg::CFG_DATA_W-1:0]           pwdata,
  output logic [afc_pkg::CFG_DATA_W-1:0]           prdata,
  output afc_pkg::plane_t [NUM_PLANES-1:0]         planes
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[afc_pkg::CFG_ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    if (p < afc_pkg::REG_COUNT) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          planes[p] <= '0;
        end else if (wr_en && reg_idx == 3'(p)) begin
          planes[p] <= pwdata;
        end
      end
    end else begin : g_zero
      assign planes[p] = '0;
    end
  end

  always_comb begin
    prdata = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (p < afc_pkg::REG_COUNT && reg_idx == 3'(p)) begin
        prdata = planes[p];
      end
    end
  end

endmodule

>>> hw/rtl/afc_plane_eval.sv
// One plane test: picks the corner furthest along the plane normal,
// registers the three products and the aligned offset, flags a negative sum.
// Depends on afc_pkg for coefficient layout and stage control.
`timescale 1ns / 1ps

module afc_plane_eval #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  afc_pkg::stage_ctl_t           ctl,
  input  afc_pkg::plane_t               plane,
  input  logic signed [COORD_BITS-1:0]  x_max,
  input  logic signed [COORD_BITS-1:0]  x_min,
  input  logic signed [COORD_BITS-1:0]  y_max,
  input  logic signed [COORD_BITS-1:0]  y_min,
  input  logic signed [COORD_BITS-1:0]  z_max,
  input  logic signed [COORD_BITS-1:0]  z_min,
  output logic                          outside
);

  localparam int CW     = afc_pkg::COEF_W;
  localparam int PROD_W = CW + COORD_BITS;
  localparam int BASE_W = (PROD_W > afc_pkg::D_W) ? PROD_W : afc_pkg::D_W;
  localparam int SUM_W  = BASE_W + 2;

  logic signed [CW-1:0]          coef_a;
  logic signed [CW-1:0]          coef_b;
  logic signed [CW-1:0]          coef_c;
  logic signed [CW-1:0]          coef_d;
  logic signed [COORD_BITS-1:0]  vx;
  logic signed [COORD_BITS-1:0]  vy;
  logic signed [COORD_BITS-1:0]  vz;
  logic signed [PROD_W-1:0]      prod_x;
  logic signed [PROD_W-1:0]      prod_y;
  logic signed [PROD_W-1:0]      prod_z;
  logic signed [afc_pkg::D_W-1:0] off_d;
  logic signed [SUM_W-1:0]       plane_sum;

  assign coef_a = plane[afc_pkg::POS_A*CW +: CW];
  assign coef_b = plane[afc_pkg::POS_B*CW +: CW];
  assign coef_c = plane[afc_pkg::POS_C*CW +: CW];
  assign coef_d = plane[afc_pkg::POS_D*CW +: CW];

  // corner with the largest signed distance
  assign vx = coef_a[CW-1] ? x_min : x_max;
  assign vy = coef_b[CW-1] ? y_min : y_max;
  assign vz = coef_c[CW-1] ? z_min : z_max;

  always_ff @(posedge clk) begin
    if (ctl.load && ctl.valid) begin
      prod_x <= PROD_W'(coef_a) * PROD_W'(vx);
      prod_y <= PROD_W'(coef_b) * PROD_W'(vy);
      prod_z <= PROD_W'(coef_c) * PROD_W'(vz);
      off_d  <= {coef_d, {afc_pkg::D_ALIGN{1'b0}}};
    end
  end

  assign plane_sum = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z) + SUM_W'(off_d);
  assign outside = plane_sum[SUM_W-1];

endmodule

>>> hw/rtl/aabb_frustum_cull.sv
// Top level of the AABB frustum cull block: stream ports, APB plane registers,
// three-stage pipeline. Depends on afc_pkg, afc_plane_regs, afc_plane_eval.
//
//  channel   | dir | beat contents (lowest bits first)
//  ----------+-----+---------------------------------------------------
//  s_tdata   | in  | lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (COORD_BITS each)
//  m_tdata   | out | visible, zero padding to 8 bits
//  apb       | in  | planes left, right, bottom, top, near, far at 8*i
//
// One box per cycle sustained while m_tready stays high; an accepted beat passes
// the input register, the product register and the result register in turn
// before it shows on m_tdata and can leave.
// Each plane needs one 16 x COORD_BITS multiply per axis on the chosen corner.
// Reset clears the stage valid flags and the plane registers to zero.
// Stages advance independently, so bubbles collapse while the output stalls.
`timescale 1ns / 1ps

module aabb_frustum_cull #(
  parameter int NUM_PLANES = 6,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // visible, zero padding
  output logic [afc_pkg::OUT_W-1:0]         m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [afc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [afc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [afc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int CB = COORD_BITS;

  afc_pkg::plane_t [NUM_PLANES-1:0] planes;

  logic signed [CB-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic signed [CB-1:0] x_max, x_min, y_max, y_min, z_max, z_min;
  logic                 in_valid;
  logic                 prod_valid;
  logic                 ld_in, ld_prod, ld_out;
  logic [NUM_PLANES-1:0] outside;
  afc_pkg::stage_ctl_t  ctl;
  logic                 visible;

  assign pready = 1'b1;

  afc_plane_regs #(
    .NUM_PLANES (NUM_PLANES)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .planes  (planes)
  );

  assign lo_x = s_tdata[0*CB +: CB];
  assign lo_y = s_tdata[1*CB +: CB];
  assign lo_z = s_tdata[2*CB +: CB];
  assign hi_x = s_tdata[3*CB +: CB];
  assign hi_y = s_tdata[4*CB +: CB];
  assign hi_z = s_tdata[5*CB +: CB];

  assign ld_out   = !m_tvalid || m_tready;
  assign ld_prod  = !prod_valid || ld_out;
  assign ld_in    = !in_valid || ld_prod;
  assign s_tready = ld_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      prod_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (ld_in) begin
        in_valid <= s_tvalid;
      end
      if (ld_prod) begin
        prod_valid <= in_valid;
      end
      if (ld_out) begin
        m_tvalid <= prod_valid;
      end
    end
  end

  // order each axis on entry so corner selection is a plain mux
  always_ff @(posedge clk) begin
    if (ld_in && s_tvalid) begin
      x_max <= (hi_x > lo_x) ? hi_x : lo_x;
      x_min <= (hi_x > lo_x) ? lo_x : hi_x;
      y_max <= (hi_y > lo_y) ? hi_y : lo_y;
      y_min <= (hi_y > lo_y) ? lo_y : hi_y;
      z_max <= (hi_z > lo_z) ? hi_z : lo_z;
      z_min <= (hi_z > lo_z) ? lo_z : hi_z;
    end
  end

  assign ctl.load  = ld_prod;
  assign ctl.valid = in_valid;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_eval
    afc_plane_eval #(
      .COORD_BITS (COORD_BITS)
    ) u_eval (
      .clk     (clk),
      .ctl     (ctl),
      .plane   (planes[p]),
      .x_max   (x_max),
      .x_min   (x_min),
      .y_max   (y_max),
      .y_min   (y_min),
      .z_max   (z_max),
      .z_min   (z_min),
      .outside (outside[p])
    );
  end

  always_ff @(posedge clk) begin
    if (ld_out && prod_valid) begin
      visible <= ~|outside;
    end
  end

  assign m_tdata = {{(afc_pkg::OUT_W-1){1'b0}}, visible};

endmodule

>>> hw/rtl/afc_checker.sv
// Port-level checks for the AABB frustum cull block, bound to the top level.
// Depends on afc_pkg for the result width.
`timescale 1ns / 1ps

module afc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [afc_pkg::OUT_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with free output");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("box beat did not reach output");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[afc_pkg::OUT_W-1:1] == '0)
    else $error("result padding not zero");

endmodule

bind aabb_frustum_cull afc_checker u_chk (.*);

>>> dv/testbench.sv
// Self-checking bench for aabb_frustum_cull: streams boxes under random bursts and stalls,
// predicts the visibility bit of each accepted box and scores every output beat.
// Depends on afc_pkg and the aabb_frustum_cull RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_W      = 16;
  localparam int BOX_W        = ((6*COORD_W+7)/8)*8;
  localparam int CW           = afc_pkg::COEF_W;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_MAX = 5000;
  localparam int PHASES       = 12;
  localparam int PHASE_BOXES  = 160;

  typedef enum int {
    PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR,
    PLANE_SPARE0, PLANE_SPARE1
  } plane_idx_t;

  typedef enum logic [2:0] {
    RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE, RX_BLOCKS
  } rx_mode_t;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [BOX_W-1:0]               s_tdata  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [afc_pkg::OUT_W-1:0]      m_tdata;
  logic                           psel     = 1'b0;
  logic                           penable  = 1'b0;
  logic                           pwrite   = 1'b0;
  logic [afc_pkg::CFG_ADDR_W-1:0] paddr    = '0;
  logic [afc_pkg::CFG_DATA_W-1:0] pwdata   = '0;
  logic [afc_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  afc_pkg::plane_t  plane_cfg [afc_pkg::REG_COUNT];
  logic [BOX_W-1:0] pending_boxes [$];
  logic             expected_visible [$];
  int               mismatch_count = 0;
  int               idle_cycles    = 0;
  int               burst_left     = 0;
  int               gap_left       = 0;
  rx_mode_t         rx_mode        = RX_OPEN;
  int               mode_left      = 0;
  int               hold_left      = 0;

  afc_pkg::plane_t extreme_planes [4] = '{
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h8000_8000_8000_8000,
    64'h7FFF_7FFF_7FFF_7FFF,
    64'h0000_0000_0000_8000
  };

  aabb_frustum_cull #(
    .NUM_PLANES(6),
    .COORD_BITS(COORD_W)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),   // visible, zero padding
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  function automatic logic box_visible(input logic [BOX_W-1:0] box);
    longint xs [2];
    longint ys [2];
    longint zs [2];
    longint a, b, c, d, s;
    int     neg;
    logic   vis;
    vis   = 1'b1;
    xs[0] = longint'($signed(box[0*COORD_W +: COORD_W]));
    ys[0] = longint'($signed(box[1*COORD_W +: COORD_W]));
    zs[0] = longint'($signed(box[2*COORD_W +: COORD_W]));
    xs[1] = longint'($signed(box[3*COORD_W +: COORD_W]));
    ys[1] = longint'($signed(box[4*COORD_W +: COORD_W]));
    zs[1] = longint'($signed(box[5*COORD_W +: COORD_W]));
    for (int p = 0; p < afc_pkg::REG_COUNT; p++) begin
      a   = longint'($signed(plane_cfg[p][afc_pkg::POS_A*CW +: CW]));
      b   = longint'($signed(plane_cfg[p][afc_pkg::POS_B*CW +: CW]));
      c   = longint'($signed(plane_cfg[p][afc_pkg::POS_C*CW +: CW]));
      d   = longint'($signed(plane_cfg[p][afc_pkg::POS_D*CW +: CW]))
            * (longint'(1) << afc_pkg::D_ALIGN);
      neg = 0;
      for (int k = 0; k < 8; k++) begin
        s = a * xs[k & 1] + b * ys[(k >> 1) & 1] + c * zs[(k >> 2) & 1] + d;
        if (s < 0) neg++;
      end
      if (neg == 8) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic logic [BOX_W-1:0] make_box(input int lx, input int ly, input int lz,
                                                 input int hx, input int hy, input int hz);
    return {16'(hz), 16'(hy), 16'(hx), 16'(lz), 16'(ly), 16'(lx)};
  endfunction

  function automatic afc_pkg::plane_t make_plane(input int a, input int b, input int c,
                                                 input int d);
    return {16'(a), 16'(b), 16'(c), 16'(d)};
  endfunction

  function automatic logic [BOX_W-1:0] random_box();
    int r, cx, cy, cz, hx, hy, hz;
    logic [BOX_W-1:0] box;
    r  = $urandom_range(0, 9);
    cx = int'($urandom_range(0, 16000)) - 8000;
    cy = int'($urandom_range(0, 16000)) - 8000;
    cz = int'($urandom_range(0, 16000)) - 6000;
    hx = $urandom_range(0, 640);
    hy = $urandom_range(0, 640);
    hz = $urandom_range(0, 640);
    if (r < 2) begin
      box = {$urandom, $urandom, $urandom};
    end else if (r < 8) begin
      box = make_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
    end else begin
      box = make_box(cx + hx, cy + hy, cz + hz, cx - hx, cy - hy, cz - hz);
    end
    return box;
  endfunction

  // append a box to the send queue
  task automatic queue_box(input logic [BOX_W-1:0] box);
    pending_boxes.insert(pending_boxes.size(), box);
  endtask

  task automatic cfg_write(input int idx, input afc_pkg::plane_t val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= afc_pkg::CFG_ADDR_W'(idx * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < afc_pkg::REG_COUNT) plane_cfg[idx] = val;
  endtask

  task automatic wait_idle();
    while (pending_boxes.size() != 0 || s_tvalid || expected_visible.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_boxes.size() != 0) begin
        s_tdata  <= pending_boxes.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches mode at random intervals
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      mode_left <= 0;
      hold_left <= 0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 4));
        mode_left <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
        RX_SPARSE: m_tready <= ($urandom_range(0, 9) < 3);
        RX_TOGGLE: m_tready <= ~m_tready;
        default: begin
          if (hold_left == 0) begin
            m_tready  <= ~m_tready;
            hold_left <= m_tready ? $urandom_range(1, 20) : $urandom_range(1, 10);
          end else begin
            hold_left <= hold_left - 1;
          end
        end
      endcase
    end
  end

  // predict on input beats, score output beats, guard against a hang
  always @(posedge clk) begin
    logic exp_vis;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_visible.insert(expected_visible.size(), box_visible(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_visible.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected output beat: m_tdata %0h", m_tdata);
          mismatch_count++;
        end else begin
          exp_vis = expected_visible.pop_front();
          if (m_tdata !== {{(afc_pkg::OUT_W-1){1'b0}}, exp_vis}) begin
            if (mismatch_count < 10)
              $display("visible mismatch: expected %0d got m_tdata %0h", exp_vis, m_tdata);
            mismatch_count++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("** aabb_frustum_cull: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int w, h, n, f, t0, t1, t2;
    afc_pkg::plane_t pat;
    for (int i = 0; i < afc_pkg::REG_COUNT; i++) plane_cfg[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // all-zero planes after reset: nothing culls
    queue_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    queue_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    queue_box(make_box(32767, -32768, 32767, -32768, 32767, -32768));
    queue_box({$urandom, $urandom, $urandom});
    wait_idle();

    // axis-aligned frustum: 0 <= x <= 100, -100 <= y <= 100, 0 <= z <= 200
    cfg_write(PLANE_LEFT,   make_plane(16'h4000, 0, 0, 0));
    cfg_write(PLANE_RIGHT,  make_plane(16'hC000, 0, 0, 16'h0640));
    cfg_write(PLANE_BOTTOM, make_plane(0, 16'h4000, 0, 16'h0640));
    cfg_write(PLANE_TOP,    make_plane(0, 16'hC000, 0, 16'h0640));
    cfg_write(PLANE_NEAR,   make_plane(0, 0, 16'h4000, 0));
    cfg_write(PLANE_FAR,    make_plane(0, 0, 16'hC000, 16'h0C80));
    cfg_write(PLANE_SPARE0, 64'h0000_0000_0000_8000);
    cfg_write(PLANE_SPARE1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_box(make_box(16, 16, 16, 32, 32, 32));
    queue_box(make_box(32, 32, 32, 16, 16, 16));
    queue_box(make_box(0, 0, 0, 0, 0, 0));
    queue_box(make_box(-32, 0, 16, -1, 16, 32));
    queue_box(make_box(-1, 16, 32, -32, 0, 16));
    queue_box(make_box(-16, 0, 16, 16, 16, 32));
    queue_box(make_box(1601, 0, 16, 2000, 16, 32));
    queue_box(make_box(1600, 0, 16, 1600, 16, 32));
    queue_box(make_box(16, 1601, 16, 32, 1700, 32));
    queue_box(make_box(16, -1700, 16, 32, -1601, 32));
    queue_box(make_box(16, 16, -64, 32, 32, -1));
    queue_box(make_box(16, 16, 3200, 32, 32, 3200));
    queue_box(make_box(16, 16, 3201, 32, 32, 4000));
    queue_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    queue_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    queue_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    queue_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0, 1: begin
          w  = 16 * $urandom_range(20, 400);
          h  = 16 * $urandom_range(20, 400);
          n  = 16 * $urandom_range(0, 100);
          f  = n + 16 * $urandom_range(50, 600);
          t0 = int'($urandom_range(0, 2000)) - 1000;
          t1 = int'($urandom_range(0, 2000)) - 1000;
          t2 = int'($urandom_range(0, 2000)) - 1000;
          cfg_write(PLANE_LEFT,   make_plane(16384 + t0, t1, t2, w));
          cfg_write(PLANE_RIGHT,  make_plane(-16384 + t1, t2, t0, w));
          cfg_write(PLANE_BOTTOM, make_plane(t2, 16384 + t0, t1, h));
          cfg_write(PLANE_TOP,    make_plane(t0, -16384 + t2, t1, h));
          cfg_write(PLANE_NEAR,   make_plane(t1, t0, 16384 + t2, -n));
          cfg_write(PLANE_FAR,    make_plane(t2, t1, -16384 + t0, f));
        end
        2: begin
          for (int i = PLANE_LEFT; i <= PLANE_FAR; i++) cfg_write(i, {$urandom, $urandom});
        end
        default: begin
          pat = extreme_planes[ph / 4];
          for (int i = PLANE_LEFT; i < PLANE_FAR; i++) cfg_write(i, pat);
          cfg_write(PLANE_FAR, '0);
        end
      endcase
      repeat (PHASE_BOXES) queue_box(random_box());
      wait_idle();
    end

    if (expected_visible.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("** aabb_frustum_cull: PASSED **");
    end else begin
      $display("** aabb_frustum_cull: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/afc_pkg.sv
hw/rtl/afc_plane_regs.sv
hw/rtl/afc_plane_eval.sv
hw/rtl/aabb_frustum_cull.sv
hw/rtl/afc_checker.sv
dv/testbench.sv
